[src/limited_integrator_with_alarms_top_assert.svh]
// Assertion macros for the limited integrator top level.
// Both expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef LIMITED_INTEGRATOR_WITH_ALARMS_TOP_ASSERT_SVH
`define LIMITED_INTEGRATOR_WITH_ALARMS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LIA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lia: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lia: next-cycle check failed");

`endif

[src/lia_pkg.sv]
`default_nettype none

package lia_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned MarginW = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracSh  = 24;
  localparam int unsigned ProdW   = 2 * WordW;
  localparam int unsigned IncW    = ProdW - FracSh;
  localparam int unsigned SumW    = IncW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN        = 3'd0,
    CFG_HIGH_LIMIT  = 3'd1,
    CFG_LOW_LIMIT   = 3'd2,
    CFG_HIGH_ALARM  = 3'd3,
    CFG_LOW_ALARM   = 3'd4,
    CFG_HIGH_MARGIN = 3'd5,
    CFG_LOW_MARGIN  = 3'd6,
    CFG_DEAD_ZONE   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEL_PRESET,
    SEL_OLD,
    SEL_SAMPLE,
    SEL_SUM
  } sel_e;

  typedef struct packed {
    logic                    enable;
    logic                    load_preset;
    logic                    hold;
    logic                    track;
    logic signed [WordW-1:0] sample;
    logic signed [WordW-1:0] preset_value;
  } lia_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] value;
    logic                    enabled_out;
    logic                    at_high_limit;
    logic                    at_low_limit;
    logic                    above_high_alarm;
    logic                    above_high_prealarm;
    logic                    below_low_prealarm;
    logic                    below_low_alarm;
    logic                    at_preset;
  } lia_out_t;

  typedef struct packed {
    logic signed [WordW-1:0] gain;
    logic signed [WordW-1:0] high_limit;
    logic signed [WordW-1:0] low_limit;
    logic signed [WordW-1:0] high_alarm;
    logic signed [WordW-1:0] low_alarm;
    logic [MarginW-1:0]      high_margin;
    logic [MarginW-1:0]      low_margin;
    logic [MarginW-1:0]      dead_zone;
  } lia_cfg_t;

  typedef struct packed {
    logic                    enable;
    sel_e                    sel;
    logic signed [WordW-1:0] sample;
    logic signed [WordW-1:0] preset_value;
    logic signed [IncW-1:0]  inc;
  } lia_mid_t;

endpackage

`default_nettype wire

[src/lia_cfg.sv]
`default_nettype none

module lia_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      we_i,
  input  wire lia_pkg::cfg_idx_e         idx_i,
  input  wire logic [lia_pkg::WordW-1:0] wdata_i,
  output lia_pkg::lia_cfg_t              cfg_o
);

  lia_pkg::lia_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain        <= '0;
      cfg_q.high_limit  <= {1'b0, {(lia_pkg::WordW-1){1'b1}}};
      cfg_q.low_limit   <= {1'b1, {(lia_pkg::WordW-1){1'b0}}};
      cfg_q.high_alarm  <= {1'b0, {(lia_pkg::WordW-1){1'b1}}};
      cfg_q.low_alarm   <= {1'b1, {(lia_pkg::WordW-1){1'b0}}};
      cfg_q.high_margin <= '0;
      cfg_q.low_margin  <= '0;
      cfg_q.dead_zone   <= '0;
    end else if (we_i) begin
      unique case (idx_i)
        lia_pkg::CFG_GAIN:        cfg_q.gain        <= $signed(wdata_i);
        lia_pkg::CFG_HIGH_LIMIT:  cfg_q.high_limit  <= $signed(wdata_i);
        lia_pkg::CFG_LOW_LIMIT:   cfg_q.low_limit   <= $signed(wdata_i);
        lia_pkg::CFG_HIGH_ALARM:  cfg_q.high_alarm  <= $signed(wdata_i);
        lia_pkg::CFG_LOW_ALARM:   cfg_q.low_alarm   <= $signed(wdata_i);
        lia_pkg::CFG_HIGH_MARGIN: cfg_q.high_margin <= wdata_i[lia_pkg::MarginW-1:0];
        lia_pkg::CFG_LOW_MARGIN:  cfg_q.low_margin  <= wdata_i[lia_pkg::MarginW-1:0];
        lia_pkg::CFG_DEAD_ZONE:   cfg_q.dead_zone   <= wdata_i[lia_pkg::MarginW-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/lia_mac.sv]
`default_nettype none

module lia_mac (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lia_pkg::lia_cfg_t cfg_i,
  input  wire logic              in_valid_i,
  input  wire lia_pkg::lia_in_t  in_i,
  output logic                   in_stall_o,
  output logic                   mid_valid_o,
  output lia_pkg::lia_mid_t      mid_o,
  input  wire logic              mid_ready_i
);

  logic                                 s1_valid_q;
  lia_pkg::lia_in_t                     s1_q;
  logic                                 mid_valid_q;
  lia_pkg::lia_mid_t                    mid_q;
  lia_pkg::lia_mid_t                    mid_d;
  logic                                 mid_adv;
  logic                                 s1_adv;
  logic signed [lia_pkg::ProdW-1:0]     prod;
  logic [lia_pkg::WordW-1:0]            mag;
  logic                                 dead;

  assign mid_adv    = !mid_valid_q || mid_ready_i;
  assign s1_adv     = !s1_valid_q || mid_adv;
  assign in_stall_o = !s1_adv;

  // Dropping the low 24 bits floors the Q24.40 product to Q24.16.
  assign prod = lia_pkg::ProdW'(cfg_i.gain) * lia_pkg::ProdW'(s1_q.sample);
  assign mag  = s1_q.sample[lia_pkg::WordW-1] ? lia_pkg::WordW'(-s1_q.sample)
                                               : lia_pkg::WordW'(s1_q.sample);
  assign dead = (cfg_i.dead_zone != '0) && (mag < {1'b0, cfg_i.dead_zone});

  always_comb begin
    mid_d.enable       = s1_q.enable;
    mid_d.sample       = s1_q.sample;
    mid_d.preset_value = s1_q.preset_value;
    mid_d.inc          = prod[lia_pkg::ProdW-1:lia_pkg::FracSh];
    priority if (s1_q.load_preset) begin
      mid_d.sel = lia_pkg::SEL_PRESET;
    end else if (s1_q.hold) begin
      mid_d.sel = lia_pkg::SEL_OLD;
    end else if (s1_q.track) begin
      mid_d.sel = lia_pkg::SEL_SAMPLE;
    end else if (dead) begin
      mid_d.sel = lia_pkg::SEL_OLD;
    end else begin
      mid_d.sel = lia_pkg::SEL_SUM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (mid_adv) begin
        mid_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_adv) begin
      s1_q <= in_i;
    end
    if (s1_valid_q && mid_adv) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

endmodule

`default_nettype wire

[src/lia_upd.sv]
`default_nettype none

module lia_upd (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lia_pkg::lia_cfg_t cfg_i,
  input  wire logic              mid_valid_i,
  input  wire lia_pkg::lia_mid_t mid_i,
  output logic                   mid_ready_o,
  output logic                   out_valid_o,
  output lia_pkg::lia_out_t      out_o,
  input  wire logic              out_stall_i
);

  typedef struct packed {
    logic at_high_limit;
    logic at_low_limit;
    logic above_high_alarm;
    logic above_high_prealarm;
    logic below_low_prealarm;
    logic below_low_alarm;
    logic at_preset;
  } flags_t;

  localparam int unsigned CmpW = lia_pkg::WordW + 2;

  logic                              out_valid_q;
  lia_pkg::lia_out_t                 out_q;
  lia_pkg::lia_out_t                 out_d;
  logic                              started_q;
  logic signed [lia_pkg::WordW-1:0]  held_value_q;
  flags_t                            held_flags_q;
  flags_t                            flags;
  logic                              out_adv;
  logic                              fire;
  logic signed [lia_pkg::WordW-1:0]  old;
  logic signed [lia_pkg::SumW-1:0]   sum;
  logic signed [lia_pkg::SumW-1:0]   cand;
  logic signed [lia_pkg::SumW-1:0]   after_hi;
  logic signed [lia_pkg::SumW-1:0]   lim;
  logic signed [lia_pkg::WordW-1:0]  value;
  logic signed [CmpW-1:0]            value_x;
  logic signed [CmpW-1:0]            ha_pre;
  logic signed [CmpW-1:0]            la_pre;

  assign out_adv     = !out_valid_q || !out_stall_i;
  assign mid_ready_o = out_adv;
  assign fire        = mid_valid_i && out_adv;

  assign old = started_q ? held_value_q : mid_i.preset_value;
  assign sum = lia_pkg::SumW'(old) + lia_pkg::SumW'(mid_i.inc);

  always_comb begin
    unique case (mid_i.sel)
      lia_pkg::SEL_PRESET: cand = lia_pkg::SumW'(mid_i.preset_value);
      lia_pkg::SEL_OLD:    cand = lia_pkg::SumW'(old);
      lia_pkg::SEL_SAMPLE: cand = lia_pkg::SumW'(mid_i.sample);
      lia_pkg::SEL_SUM:    cand = sum;
    endcase
  end

  // High clamp first, then low clamp, so crossed limits end at the low limit.
  assign flags.at_high_limit = cand >= lia_pkg::SumW'(cfg_i.high_limit);
  assign after_hi = flags.at_high_limit ? lia_pkg::SumW'(cfg_i.high_limit) : cand;
  assign flags.at_low_limit = after_hi <= lia_pkg::SumW'(cfg_i.low_limit);
  assign lim   = flags.at_low_limit ? lia_pkg::SumW'(cfg_i.low_limit) : after_hi;
  assign value = lim[lia_pkg::WordW-1:0];

  assign value_x = CmpW'(value);
  assign ha_pre  = CmpW'(cfg_i.high_alarm) - $signed({3'b000, cfg_i.high_margin});
  assign la_pre  = CmpW'(cfg_i.low_alarm) + $signed({3'b000, cfg_i.low_margin});

  assign flags.above_high_alarm    = value > cfg_i.high_alarm;
  assign flags.above_high_prealarm = value_x > ha_pre;
  assign flags.below_low_prealarm  = value_x < la_pre;
  assign flags.below_low_alarm     = value < cfg_i.low_alarm;
  assign flags.at_preset           = value == mid_i.preset_value;

  always_comb begin
    flags_t f;
    f = mid_i.enable ? flags : held_flags_q;
    out_d.value               = mid_i.enable ? value : held_value_q;
    out_d.enabled_out         = mid_i.enable;
    out_d.at_high_limit       = f.at_high_limit;
    out_d.at_low_limit        = f.at_low_limit;
    out_d.above_high_alarm    = f.above_high_alarm;
    out_d.above_high_prealarm = f.above_high_prealarm;
    out_d.below_low_prealarm  = f.below_low_prealarm;
    out_d.below_low_alarm     = f.below_low_alarm;
    out_d.at_preset           = f.at_preset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      started_q    <= 1'b0;
      held_value_q <= '0;
      held_flags_q <= '0;
    end else begin
      if (out_adv) begin
        out_valid_q <= mid_valid_i;
      end
      if (fire) begin
        started_q <= 1'b1;
        if (mid_i.enable) begin
          held_value_q <= value;
          held_flags_q <= flags;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

[src/limited_integrator_with_alarms_top.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o   lia_pkg::lia_in_t in_i
// out       output     out_valid_o/out_stall_i lia_pkg::lia_out_t out_o
// cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One word is accepted per cycle while in_stall_o is low.
// The input register, the product register and the result register form the pipe;
// the value loop closes in the last stage alone, so words follow back to back.
// Reset clears all valid bits, the held value, the held flags and the first-word mark.
// A stalled result holds the pipe only where it is full; bubbles still fill up.
`default_nettype none

`include "limited_integrator_with_alarms_top_assert.svh"

module limited_integrator_with_alarms_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire lia_pkg::cfg_idx_e         cfg_idx_i,
  input  wire logic [lia_pkg::WordW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  input  wire lia_pkg::lia_in_t          in_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  output lia_pkg::lia_out_t              out_o,
  input  wire logic                      out_stall_i
);

  lia_pkg::lia_cfg_t cfg;
  logic              mid_valid;
  lia_pkg::lia_mid_t mid;
  logic              mid_ready;

  lia_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lia_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .mid_valid_o (mid_valid),
    .mid_o       (mid),
    .mid_ready_i (mid_ready)
  );

  lia_upd u_upd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mid_valid_i (mid_valid),
    .mid_i       (mid),
    .mid_ready_o (mid_ready),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

  `LIA_ASSERT_NOW(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i)
  `LIA_ASSERT_NOW(a_high_alarm_implies_pre, out_valid_o && out_o.above_high_alarm, out_o.above_high_prealarm)
  `LIA_ASSERT_NOW(a_low_alarm_implies_pre, out_valid_o && out_o.below_low_alarm, out_o.below_low_prealarm)
  `LIA_ASSERT_NEXT(a_mid_holds, mid_valid && !mid_ready, mid_valid && $stable(mid))

endmodule

`default_nettype wire

[test/limited_integrator_with_alarms_top_tb.sv]
module limited_integrator_with_alarms_top_tb;
  import lia_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned PhaseWords = 260;
  localparam int unsigned RandPhases = 7;
  localparam int unsigned PrintCap   = 200;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  cfg_idx_e         cfg_idx   = CFG_GAIN;
  logic [WordW-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  lia_in_t          in_word   = '0;
  logic             in_stall;
  logic             out_valid;
  lia_out_t         out_word;
  logic             out_stall = 1'b0;

  lia_in_t          word_q[$];
  lia_out_t         result_q[$];
  lia_cfg_t         regs;
  lia_out_t         held;
  bit               started;
  bit               in_took;
  bit               steady;
  logic [WordW-1:0] prev_preset;
  int unsigned      errors;
  int unsigned      words_in;
  int unsigned      results_out;
  int unsigned      quiet_cycles;
  int unsigned      settings_used;

  limited_integrator_with_alarms_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_i       (in_word),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_o      (out_word),
    .out_stall_i(out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Value and flags that the integrator produces for one word; updates the held state.
  function automatic lia_out_t integrate_step(lia_in_t w);
    longint   smp, pre, prior, nxt, gain, dz, hl, ll, ha, la, hm, lm, mag;
    lia_out_t r;
    smp = $signed(w.sample);
    pre = $signed(w.preset_value);
    if (w.enable) begin
      if (started) begin
        prior = $signed(held.value);
      end else begin
        prior = pre;
      end
      gain = $signed(regs.gain);
      hl   = $signed(regs.high_limit);
      ll   = $signed(regs.low_limit);
      ha   = $signed(regs.high_alarm);
      la   = $signed(regs.low_alarm);
      hm   = regs.high_margin;
      lm   = regs.low_margin;
      dz   = regs.dead_zone;
      mag  = (smp < 0) ? -smp : smp;
      if (w.load_preset) begin
        nxt = pre;
      end else if (w.hold) begin
        nxt = prior;
      end else if (w.track) begin
        nxt = smp;
      end else if (dz != 0 && mag < dz) begin
        nxt = prior;
      end else begin
        nxt = prior + ((gain * smp) >>> FracSh);
      end
      r = '0;
      if (nxt >= hl) begin
        nxt = hl;
        r.at_high_limit = 1'b1;
      end
      if (nxt <= ll) begin
        nxt = ll;
        r.at_low_limit = 1'b1;
      end
      r.above_high_alarm    = nxt > ha;
      r.above_high_prealarm = nxt > ha - hm;
      r.below_low_prealarm  = nxt < la + lm;
      r.below_low_alarm     = nxt < la;
      r.at_preset           = nxt == pre;
      r.value               = nxt[WordW-1:0];
      held = r;
    end
    started = 1'b1;
    r = held;
    r.enabled_out = w.enable;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    errors++;
    if (errors <= PrintCap) begin
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic compare_result(lia_out_t got, lia_out_t want);
    if (got.value !== want.value)
      report_mismatch("value", got.value, want.value);
    if (got.enabled_out !== want.enabled_out)
      report_mismatch("enabled_out", got.enabled_out, want.enabled_out);
    if (got.at_high_limit !== want.at_high_limit)
      report_mismatch("at_high_limit", got.at_high_limit, want.at_high_limit);
    if (got.at_low_limit !== want.at_low_limit)
      report_mismatch("at_low_limit", got.at_low_limit, want.at_low_limit);
    if (got.above_high_alarm !== want.above_high_alarm)
      report_mismatch("above_high_alarm", got.above_high_alarm, want.above_high_alarm);
    if (got.above_high_prealarm !== want.above_high_prealarm)
      report_mismatch("above_high_prealarm", got.above_high_prealarm,
                      want.above_high_prealarm);
    if (got.below_low_prealarm !== want.below_low_prealarm)
      report_mismatch("below_low_prealarm", got.below_low_prealarm,
                      want.below_low_prealarm);
    if (got.below_low_alarm !== want.below_low_alarm)
      report_mismatch("below_low_alarm", got.below_low_alarm, want.below_low_alarm);
    if (got.at_preset !== want.at_preset)
      report_mismatch("at_preset", got.at_preset, want.at_preset);
  endtask

  always @(negedge clk) begin : drive_words
    logic    next_valid;
    lia_in_t next_word;
    next_valid = in_valid;
    next_word  = in_word;
    if (in_took) begin
      void'(word_q.pop_front());
      next_valid = 1'b0;
    end
    if (!next_valid && rst_n && word_q.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
      next_valid = 1'b1;
      next_word  = word_q[0];
    end
    in_valid <= next_valid;
    in_word  <= next_word;
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        result_q.push_back(integrate_step(in_word));
        words_in++;
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_word.value, '0);
        end else begin
          compare_result(out_word, result_q.pop_front());
        end
        results_out++;
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout after %0d cycles without a handshake.", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [WordW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_GAIN:        regs.gain        = data;
      CFG_HIGH_LIMIT:  regs.high_limit  = data;
      CFG_LOW_LIMIT:   regs.low_limit   = data;
      CFG_HIGH_ALARM:  regs.high_alarm  = data;
      CFG_LOW_ALARM:   regs.low_alarm   = data;
      CFG_HIGH_MARGIN: regs.high_margin = data[MarginW-1:0];
      CFG_LOW_MARGIN:  regs.low_margin  = data[MarginW-1:0];
      CFG_DEAD_ZONE:   regs.dead_zone   = data[MarginW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [WordW-1:0] g, logic [WordW-1:0] hl,
                                logic [WordW-1:0] ll, logic [WordW-1:0] ha,
                                logic [WordW-1:0] la, logic [WordW-1:0] hm,
                                logic [WordW-1:0] lm, logic [WordW-1:0] dz);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_HIGH_LIMIT, hl);
    write_reg(CFG_LOW_LIMIT, ll);
    write_reg(CFG_HIGH_ALARM, ha);
    write_reg(CFG_LOW_ALARM, la);
    write_reg(CFG_HIGH_MARGIN, hm);
    write_reg(CFG_LOW_MARGIN, lm);
    write_reg(CFG_DEAD_ZONE, dz);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic queue_word(bit en, bit ld, bit hd, bit tr, logic [WordW-1:0] smp,
                            logic [WordW-1:0] pre);
    lia_in_t w;
    w.enable       = en;
    w.load_preset  = ld;
    w.hold         = hd;
    w.track        = tr;
    w.sample       = smp;
    w.preset_value = pre;
    word_q.push_back(w);
  endtask

  function automatic logic [WordW-1:0] pick_level();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom();
      3:       return 32'h0000_0000;
      default: return $urandom_range(32'h00C8_0000) - 32'h0064_0000;
    endcase
  endfunction

  task automatic random_settings();
    logic signed [WordW-1:0] a, b, c, d;
    logic [WordW-1:0]        g, hm, lm, dz;
    case ($urandom_range(7))
      0:       g = 32'h7FFF_FFFF;
      1:       g = 32'h8000_0000;
      2:       g = $urandom();
      default: g = $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endcase
    a = pick_level();
    b = pick_level();
    c = pick_level();
    d = pick_level();
    if ($urandom_range(5) != 0 && a < b) begin
      {a, b} = {b, a};
    end
    if ($urandom_range(5) != 0 && c < d) begin
      {c, d} = {d, c};
    end
    hm = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0014_0000);
    lm = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0014_0000);
    case ($urandom_range(5))
      0, 1:    dz = '0;
      2:       dz = $urandom();
      default: dz = $urandom_range(32'h0001_0000);
    endcase
    apply_settings(g, a, b, c, d, hm, lm, dz);
  endtask

  function automatic lia_in_t random_word();
    lia_in_t          w;
    logic [WordW-1:0] dz_near;
    w.enable      = $urandom_range(99) < 92;
    w.load_preset = $urandom_range(99) < 6;
    w.hold        = $urandom_range(99) < 10;
    w.track       = $urandom_range(99) < 10;
    dz_near       = {1'b0, regs.dead_zone} + $urandom_range(4) - 2;
    case ($urandom_range(9))
      0:       w.sample = $urandom();
      1:       w.sample = pick_level();
      2:       w.sample = $urandom_range(1) ? dz_near : -dz_near;
      default: w.sample = $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
    if ($urandom_range(1) == 0) begin
      w.preset_value = prev_preset;
    end else begin
      w.preset_value = pick_level();
    end
    prev_preset = w.preset_value;
    return w;
  endfunction

  initial begin
    int unsigned p, n;
    regs = '{gain: '0, high_limit: 32'h7FFF_FFFF, low_limit: 32'h8000_0000,
             high_alarm: 32'h7FFF_FFFF, low_alarm: 32'h8000_0000,
             high_margin: '0, low_margin: '0, dead_zone: '0};
    held    = '0;
    started = 1'b0;
    steady  = 1'b0;
    prev_preset = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Gain of one, limits at plus and minus 100, alarms at plus and minus 80, margins of 10, dead zone 0.5.
    apply_settings(32'h0100_0000, 32'h0064_0000, 32'hFF9C_0000, 32'h0050_0000,
                   32'hFFB0_0000, 32'h000A_0000, 32'h000A_0000, 32'h0000_8000);
    queue_word(1, 0, 0, 0, 32'h0002_0000, 32'h0003_0000);
    queue_word(0, 0, 0, 0, 32'h1234_5678, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'hFFFF_8001, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'h0000_8000, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'h8000_0000, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(1, 1, 0, 0, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_word(1, 1, 0, 0, 32'h0000_0000, 32'h8000_0000);
    queue_word(1, 1, 0, 0, 32'h0000_0000, 32'h004B_0000);
    queue_word(1, 0, 1, 0, 32'h0010_0000, 32'h0000_0000);
    queue_word(1, 0, 0, 1, 32'h0055_0000, 32'h0000_0000);
    queue_word(1, 0, 0, 1, 32'hFFB5_0000, 32'h0000_0000);
    queue_word(1, 0, 0, 1, 32'hFFA6_0000, 32'h0000_0000);
    queue_word(1, 1, 1, 1, 32'h0032_0000, 32'h0001_0000);
    queue_word(1, 0, 1, 1, 32'h0032_0000, 32'h0001_0000);
    queue_word(1, 0, 0, 1, 32'h0000_0000, 32'h0000_0000);
    queue_word(0, 1, 0, 0, 32'h0000_0000, 32'h0020_0000);
    queue_word(1, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_idle();

    // Crossed limits, most negative gain, margins written with the top bit set.
    apply_settings(32'h8000_0000, 32'hFFCE_0000, 32'h0032_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'h0000_0001, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_word(1, 0, 0, 1, 32'h0000_0000, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'h8000_0000, 32'h0000_0000);
    wait_idle();

    apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_word(1, 0, 0, 0, 32'h8000_0000, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(1, 0, 0, 0, 32'h7FFF_FFFE, 32'h0000_0000);
    wait_idle();

    for (p = 0; p < RandPhases; p++) begin
      random_settings();
      steady = (p == 3);
      for (n = 0; n < PhaseWords; n++) begin
        word_q.push_back(random_word());
      end
      wait_idle();
      steady = 1'b0;
    end

    $display("Sent %0d words and checked %0d results under %0d register settings,",
             words_in, results_out, settings_used);
    $display("including crossed limits, extreme gains and margins, and the dead zone.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[limited_integrator_with_alarms_top.f]
+incdir+src
src/lia_pkg.sv
src/lia_cfg.sv
src/lia_mac.sv
src/lia_upd.sv
src/limited_integrator_with_alarms_top.sv
test/limited_integrator_with_alarms_top_tb.sv
